// File: hw/rtl/ddslpd_pkg.sv
// Shared types, constants and helpers for the straight-line PD heading block.
// Holds the word formats, register codes, controller states and the command
// and status groups that join the controller to the datapath. No dependencies.
`default_nettype none

package ddslpd_pkg;

   // Sizes
   localparam int WINDOW_MAX_DEF = 8;
   localparam int DATA_W         = 32;
   localparam int LEN_W          = 4;
   localparam int LEN_MIN        = 2;
   localparam int CSR_IDX_W      = 3;
   localparam int DIV_W          = 48;
   localparam int DIV_CNT_W      = $clog2(DIV_W);
   localparam int SAT_W          = 50;

   // Register reset values
   localparam logic signed [31:0] FWD_SPEED_RST = 32'sd65536;
   localparam logic signed [31:0] TURN_RATE_RST = 32'sd0;
   localparam logic [30:0]        BODY_WIDTH_RST = 31'd327680;
   localparam logic signed [31:0] GAIN_P_RST    = 32'sd65536;
   localparam logic signed [31:0] GAIN_D_RST    = 32'sd65536;
   localparam logic [30:0]        LIMIT_RST     = 31'd65536;
   localparam logic               USE_OFF_RST   = 1'b1;
   localparam logic [LEN_W-1:0]   WIN_LEN_RST   = 4'd5;

   // Saturation bounds
   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORWARD_SPEED  = 3'd0,
      CSR_TURNING_RATE   = 3'd1,
      CSR_BODY_WIDTH     = 3'd2,
      CSR_GAIN_P         = 3'd3,
      CSR_GAIN_D         = 3'd4,
      CSR_SPEED_LIMIT    = 3'd5,
      CSR_USE_OFFSET     = 3'd6,
      CSR_WINDOW_LENGTH  = 3'd7
   } csr_index_type;

   // Input word
   typedef struct packed {
      logic signed [31:0] left_dist;
      logic signed [31:0] right_dist;
      logic [31:0]        stamp;
   } req_type;

   // Result word
   typedef struct packed {
      logic signed [31:0] left_command;
      logic signed [31:0] right_command;
      logic               correcting;
      logic               zero_span;
   } rsp_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SELECT,
      ST_DIFF,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_RATE,
      ST_MUL_P,
      ST_MUL_D,
      ST_CL_OUT,
      ST_OL_OUT
   } ctrl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic select;
      logic diff;
      logic div_start;
      logic rate;
      logic mul_p;
      logic mul_d;
      logic load_cl;
      logic load_ol;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;
      logic span_zero;
      logic div_done;
      logic out_free;
   } status_type;

   // Clamp a wide signed value into 32-bit signed range
   function automatic logic signed [31:0] sat32_f(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'(S32_MAX);
      lo = SAT_W'(S32_MIN);
      if (v > hi) begin
         return S32_MAX;
      end else if (v < lo) begin
         return S32_MIN;
      end else begin
         return 32'(v);
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ddslpd_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on ddslpd_pkg for the dividend width and step count.
`default_nettype none

module ddslpd_div
   import ddslpd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [31:0]       divisor,
   output logic [DIV_W-1:0]       quotient,
   output logic                   done
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [31:0]          dvs_ff, dvs_in;
   logic [32:0]          shifted;
   logic [32:0]          trial;
   logic                 take;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      trial   = shifted - {1'b0, dvs_ff};
      take    = (shifted >= {1'b0, dvs_ff});
   end

   // Load on start, otherwise advance one step while busy
   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = take ? trial[31:0] : shifted[31:0];
         quo_in = {quo_ff[DIV_W-2:0], take};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ddslpd_dpath.sv
// Datapath: settings registers, sample window memory, shared multiplier,
// span divider and the result register. Depends on ddslpd_pkg, ddslpd_div.
`default_nettype none

module ddslpd_dpath
   import ddslpd_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]     csr_wdata,
   input  wire req_type               req_data,
   input  wire logic                  rsp_stall,
   output logic                       rsp_valid,
   output rsp_type                    rsp_data
);

   localparam int SLOT_W = $clog2(WINDOW_MAX);
   localparam int SUM_W  = SLOT_W + 1;

   // Settings
   logic signed [31:0] fwd_speed_ff;
   logic signed [31:0] turn_rate_ff;
   logic [30:0]        body_width_ff;
   logic signed [31:0] gain_p_ff;
   logic signed [31:0] gain_d_ff;
   logic [30:0]        limit_ff;
   logic               use_off_ff;
   logic [LEN_W-1:0]   win_len_ff;

   // Window bookkeeping
   logic [63:0]        mem [WINDOW_MAX];
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic signed [31:0] ref_off_ff, ref_off_in;
   logic               off_taken_ff, off_taken_in;
   logic [LEN_W-1:0]   len;
   logic [LEN_W:0]     fill_inc;
   logic [SUM_W-1:0]   old_sum;
   logic [SLOT_W-1:0]  old_idx;

   // Working registers
   logic signed [32:0] diff_wide;
   logic signed [31:0] diff_sat;
   logic signed [31:0] new_diff_ff;
   logic [31:0]        new_stamp_ff;
   logic [63:0]        rd_ff;
   logic signed [31:0] dp_ff, dq_ff;
   logic [31:0]        span_ff;
   logic signed [31:0] offset;
   logic signed [31:0] old_diff;
   logic [31:0]        dq_u;
   logic [31:0]        dq_mag;
   logic [DIV_W-1:0]   quotient;
   logic               div_done;
   logic signed [31:0] rate_ff, rate_in;
   logic               zero_span_ff;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod_ff;
   logic signed [47:0] vp_ff;
   logic signed [47:0] vd;
   logic signed [48:0] corr;
   logic signed [49:0] lft_w, rgt_w, lim_w;
   logic signed [31:0] lft_cl, rgt_cl;
   logic signed [46:0] half;
   logic signed [31:0] lft_ol, rgt_ol;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;
   logic               out_free;

   // Settings writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_speed_ff  <= FWD_SPEED_RST;
         turn_rate_ff  <= TURN_RATE_RST;
         body_width_ff <= BODY_WIDTH_RST;
         gain_p_ff     <= GAIN_P_RST;
         gain_d_ff     <= GAIN_D_RST;
         limit_ff      <= LIMIT_RST;
         use_off_ff    <= USE_OFF_RST;
         win_len_ff    <= WIN_LEN_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FORWARD_SPEED: fwd_speed_ff  <= $signed(csr_wdata);
            CSR_TURNING_RATE:  turn_rate_ff  <= $signed(csr_wdata);
            CSR_BODY_WIDTH:    body_width_ff <= csr_wdata[30:0];
            CSR_GAIN_P:        gain_p_ff     <= $signed(csr_wdata);
            CSR_GAIN_D:        gain_d_ff     <= $signed(csr_wdata);
            CSR_SPEED_LIMIT:   limit_ff      <= csr_wdata[30:0];
            CSR_USE_OFFSET:    use_off_ff    <= csr_wdata[0];
            CSR_WINDOW_LENGTH: win_len_ff    <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Active window length, held between the minimum and the memory depth
   always_comb begin
      if (win_len_ff < LEN_W'(LEN_MIN)) begin
         len = LEN_W'(LEN_MIN);
      end else if (32'(win_len_ff) > WINDOW_MAX) begin
         len = LEN_W'(WINDOW_MAX);
      end else begin
         len = win_len_ff;
      end
   end

   // Saturated travel difference of the incoming word
   always_comb begin
      diff_wide = 33'(req_data.left_dist) - 33'(req_data.right_dist);
      diff_sat  = sat32_f(SAT_W'(diff_wide));
   end

   // Window bookkeeping on capture
   always_comb begin
      fill_inc     = (fill_ff < len) ? ({1'b0, fill_ff} + (LEN_W+1)'(1)) : {1'b0, fill_ff};
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      ref_off_in   = ref_off_ff;
      off_taken_in = off_taken_ff;
      if (cmd.capture) begin
         fill_in = (fill_inc > {1'b0, len}) ? len : fill_inc[LEN_W-1:0];
         slot_in = (slot_ff == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_ff + SLOT_W'(1);
         if (use_off_ff && !off_taken_ff) begin
            ref_off_in   = diff_sat;
            off_taken_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         slot_ff      <= '0;
         ref_off_ff   <= '0;
         off_taken_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         slot_ff      <= slot_in;
         ref_off_ff   <= ref_off_in;
         off_taken_ff <= off_taken_in;
      end
   end

   // Slot of the oldest entry, counted back from the next write slot
   always_comb begin
      old_sum = SUM_W'(slot_ff) + SUM_W'(WINDOW_MAX) - SUM_W'(len);
      if (old_sum >= SUM_W'(WINDOW_MAX)) begin
         old_idx = SLOT_W'(old_sum - SUM_W'(WINDOW_MAX));
      end else begin
         old_idx = SLOT_W'(old_sum);
      end
   end

   // Window memory: stamp in the upper half, difference in the lower
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mem[slot_ff] <= {req_data.stamp, diff_sat};
      end
      if (cmd.select) begin
         rd_ff <= mem[old_idx];
      end
   end

   // Hold the newest sample
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         new_diff_ff  <= diff_sat;
         new_stamp_ff <= req_data.stamp;
      end
   end

   // Error, window change and time span
   always_comb begin
      offset   = use_off_ff ? ref_off_ff : 32'sd0;
      old_diff = $signed(rd_ff[31:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         dp_ff   <= sat32_f(SAT_W'(new_diff_ff) - SAT_W'(offset));
         dq_ff   <= sat32_f(SAT_W'(new_diff_ff) - SAT_W'(old_diff));
         span_ff <= new_stamp_ff - rd_ff[63:32];
      end
   end

   // Divide the scaled change magnitude by the span
   always_comb begin
      dq_u   = $unsigned(dq_ff);
      dq_mag = dq_u[31] ? (~dq_u + 32'd1) : dq_u;
   end

   ddslpd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({dq_mag, 16'h0000}),
      .divisor  (span_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // Restore the sign and saturate the rate
   always_comb begin
      if (span_ff == '0) begin
         rate_in = 32'sd0;
      end else if (dq_ff[31]) begin
         if (quotient[DIV_W-1:32] != '0 || (quotient[31] && quotient[30:0] != '0)) begin
            rate_in = S32_MIN;
         end else begin
            rate_in = $signed(~quotient[31:0] + 32'd1);
         end
      end else if (quotient[DIV_W-1:31] != '0) begin
         rate_in = S32_MAX;
      end else begin
         rate_in = $signed(quotient[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rate) begin
         rate_ff      <= rate_in;
         zero_span_ff <= (span_ff == '0);
      end
   end

   // Shared multiplier with operand selection
   always_comb begin
      if (cmd.mul_p) begin
         mul_a = gain_p_ff;
         mul_b = dp_ff;
      end else if (cmd.mul_d) begin
         mul_a = gain_d_ff;
         mul_b = rate_ff;
      end else begin
         mul_a = $signed({1'b0, body_width_ff});
         mul_b = turn_rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.select || cmd.mul_p || cmd.mul_d) begin
         prod_ff <= 64'(mul_a) * 64'(mul_b);
      end
      if (cmd.mul_d) begin
         vp_ff <= 48'(prod_ff >>> 16);
      end
   end

   // Closed-loop commands, clamped to the speed limit
   always_comb begin
      vd    = 48'(prod_ff >>> 16);
      corr  = 49'(vp_ff) + 49'(vd);
      lft_w = 50'(fwd_speed_ff) - 50'(corr);
      rgt_w = 50'(fwd_speed_ff) + 50'(corr);
      lim_w = $signed(50'(limit_ff));
      if (lft_w > lim_w) begin
         lft_cl = 32'(lim_w);
      end else if (lft_w < -lim_w) begin
         lft_cl = 32'(-lim_w);
      end else begin
         lft_cl = 32'(lft_w);
      end
      if (rgt_w > lim_w) begin
         rgt_cl = 32'(lim_w);
      end else if (rgt_w < -lim_w) begin
         rgt_cl = 32'(-lim_w);
      end else begin
         rgt_cl = 32'(rgt_w);
      end
   end

   // Open-loop commands: forward speed minus and plus half width times rate
   always_comb begin
      half   = 47'(prod_ff >>> 17);
      lft_ol = sat32_f(SAT_W'(fwd_speed_ff) - SAT_W'(half));
      rgt_ol = sat32_f(SAT_W'(fwd_speed_ff) + SAT_W'(half));
   end

   // Result register: load when free, drop once taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_cl || cmd.load_ol) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_cl) begin
         rsp_data_ff.left_command  <= lft_cl;
         rsp_data_ff.right_command <= rgt_cl;
         rsp_data_ff.correcting    <= 1'b1;
         rsp_data_ff.zero_span     <= zero_span_ff;
      end else if (cmd.load_ol) begin
         rsp_data_ff.left_command  <= lft_ol;
         rsp_data_ff.right_command <= rgt_ol;
         rsp_data_ff.correcting    <= 1'b0;
         rsp_data_ff.zero_span     <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.full      = (fill_ff == len);
   assign status.span_zero = (span_ff == '0);
   assign status.div_done  = div_done;
   assign status.out_free  = out_free;

endmodule

`default_nettype wire

// File: hw/rtl/ddslpd_ctrl.sv
// Controller: sequences one word through capture, window read and, on the
// closed-loop path, division and multiplies, then result load. Depends on ddslpd_pkg.
`default_nettype none

module ddslpd_ctrl
   import ddslpd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire status_type  status,
   output cmd_type          cmd
);

   ctrl_state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_SELECT;
         ST_SELECT:   state_in = status.full ? ST_DIFF : ST_OL_OUT;
         ST_DIFF:     state_in = ST_DIV_LOAD;
         ST_DIV_LOAD: state_in = status.span_zero ? ST_RATE : ST_DIV_RUN;
         ST_DIV_RUN:  if (status.div_done) state_in = ST_RATE;
         ST_RATE:     state_in = ST_MUL_P;
         ST_MUL_P:    state_in = ST_MUL_D;
         ST_MUL_D:    state_in = ST_CL_OUT;
         ST_CL_OUT:   if (status.out_free) state_in = ST_IDLE;
         ST_OL_OUT:   if (status.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = reset;
            cmd.capture = req_valid && !reset;
         end
         ST_SELECT:   cmd.select    = 1'b1;
         ST_DIFF:     cmd.diff      = 1'b1;
         ST_DIV_LOAD: cmd.div_start = 1'b1;
         ST_DIV_RUN:  ;
         ST_RATE:     cmd.rate      = 1'b1;
         ST_MUL_P:    cmd.mul_p     = 1'b1;
         ST_MUL_D:    cmd.mul_d     = 1'b1;
         ST_CL_OUT:   cmd.load_cl   = status.out_free;
         ST_OL_OUT:   cmd.load_ol   = status.out_free;
         default:     ;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/diff_drive_straight_line_pd.sv
// Top level of the straight-line PD heading block: controller plus datapath.
// Depends on ddslpd_pkg, ddslpd_ctrl, ddslpd_dpath.
//
//   Channel   Ports                               Carries
//   -------   ---------------------------------   -------------------------------
//   request   req_valid, req_stall, req_data      odometry word: travels, stamp
//   response  rsp_valid, rsp_stall, rsp_data      wheel commands and two flags
//   settings  csr_we, csr_index, csr_wdata        register writes, no read-back
//
// One word at a time. Open-loop words (window not yet full) go from acceptance
// through the window read to the result register. Closed-loop words go through
// the window read, the difference, the 48-step serial divider for the window
// span, the rate and both multiplies; the divider run is skipped on a zero span.
// The next word is accepted in the cycle after the result is loaded, even if
// that result is still stalled. Reset is synchronous and clears control state;
// window memory contents stay undefined until written.
`default_nettype none

module diff_drive_straight_line_pd
   import ddslpd_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [DATA_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   ddslpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ddslpd_dpath #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hw/rtl/ddslpd_chk.sv
// Port-level checks for the straight-line PD heading block, bound to the top.
// Depends on ddslpd_pkg and diff_drive_straight_line_pd.
`default_nettype none

module ddslpd_chk
   import ddslpd_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // A stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   // One word at a time: stall straight after an acceptance
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while the first is in work");

   // A zero span only arises on the closed-loop path
   a_span_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_span |-> rsp_data.correcting)
      else $error("zero span flagged on an open-loop result");

   // No result straight out of reset
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind diff_drive_straight_line_pd ddslpd_chk u_chk (.*);

`default_nettype wire
